/* design/drr_pkg.sv */
// shared types, widths and helpers for the descending run resequencer
package drr_pkg;

    localparam int VAL_W          = 11;
    localparam int MAX_VALUES_DEF = 1024;

    localparam logic [VAL_W-1:0] RESET_COUNT = 11'd1024;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             rejected;
    } item_t;

    typedef struct packed {
        logic             restart;
        logic [VAL_W-1:0] count;
    } restart_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic logic [VAL_W-1:0] sat_count(input logic [VAL_W-1:0] v,
                                                   input int unsigned max_values);
        if (32'(v) > max_values) begin
            return VAL_W'(max_values);
        end
        return v;
    endfunction

endpackage

/* design/drr_ram.sv */
// generic simple dual port ram with registered read
module drr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/drr_front.sv */
// front end: config register, input beat acceptance and range classification
module drr_front import drr_pkg::*; #(
    parameter int MAX_VALUES = MAX_VALUES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [VAL_W-1:0] s_item_value,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [VAL_W-1:0] cfg_data,
    output logic             q_push,
    output item_t            q_item,
    input  logic             q_full,
    input  back_status_t     status,
    output restart_t         restart
);

    logic [VAL_W-1:0] total_count_reg;
    logic             restart_reg;

    assign cfg_ready = 1'b1;

    // hold off items until the back end has seen the restart and finished clearing
    assign s_ready = !q_full && !status.clearing && !restart_reg;
    assign q_push  = s_valid && s_ready;

    assign q_item.value    = s_item_value;
    assign q_item.rejected = (s_item_value == '0) || (s_item_value > total_count_reg);

    assign restart.restart = restart_reg;
    assign restart.count   = total_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_count_reg <= sat_count(RESET_COUNT, MAX_VALUES);
            restart_reg     <= 1'b0;
        end else begin
            restart_reg <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                total_count_reg <= sat_count(cfg_data, MAX_VALUES);
            end
        end
    end

endmodule

/* design/drr_queue.sv */
// two entry queue between front and back end
module drr_queue import drr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* design/drr_back.sv */
// back end: presence map, release scan and result register
module drr_back import drr_pkg::*; #(
    parameter int MAX_VALUES = MAX_VALUES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  restart_t         restart,
    output back_status_t     status,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_run_top,
    output logic [VAL_W-1:0] m_run_length,
    output logic             m_all_released,
    output logic             m_rejected
);

    localparam int ADDR_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int EXT_W  = (ADDR_W > VAL_W) ? ADDR_W : VAL_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VALUES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [VAL_W-1:0]  ptr_reg, ptr_next;
    logic [VAL_W-1:0]  top_reg, top_next;
    logic [VAL_W-1:0]  len_reg, len_next;
    logic              rej_reg, rej_next;
    logic              byp_reg, byp_next;
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_run_top_reg, m_run_length_reg;
    logic              m_all_released_reg, m_rejected_reg;
    logic              load_out;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [0:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [0:0]        rd_data;
    logic [VAL_W-1:0]  ptr_dec;
    logic              present;

    // value v lives at address v-1
    function automatic logic [ADDR_W-1:0] addr_of(input logic [VAL_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v) - EXT_W'(1);
        return ext[ADDR_W-1:0];
    endfunction

    assign ptr_dec = ptr_reg - VAL_W'(1);
    // the value just set may be the one under the pointer, before the ram sees it
    assign present = rd_data[0] || byp_reg;

    drr_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VALUES),
        .ADDR_W(ADDR_W)
    ) u_map (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ptr_next     = ptr_reg;
        top_next     = top_reg;
        len_next     = len_reg;
        rej_next     = rej_reg;
        byp_next     = 1'b0;
        q_pop        = 1'b0;
        load_out     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = clr_cnt_reg;
        wr_data      = 1'b0;
        rd_addr      = addr_of(ptr_reg);
        m_valid_next = m_valid_reg && !m_ready;

        if (restart.restart) begin
            state_next   = ST_CLEAR;
            clr_cnt_next = '0;
            ptr_next     = restart.count;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    wr_en        = 1'b1;
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == LAST_ADDR) begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        q_pop    = 1'b1;
                        top_next = '0;
                        len_next = '0;
                        rej_next = q_item.rejected;
                        if (q_item.rejected || ptr_reg == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            if (q_item.value <= ptr_reg) begin
                                wr_en   = 1'b1;
                                wr_addr = addr_of(q_item.value);
                                wr_data = 1'b1;
                            end
                            byp_next   = (q_item.value == ptr_reg);
                            state_next = ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (present) begin
                        wr_en    = 1'b1;
                        wr_addr  = addr_of(ptr_reg);
                        ptr_next = ptr_dec;
                        len_next = len_reg + VAL_W'(1);
                        if (len_reg == '0) begin
                            top_next = ptr_reg;
                        end
                        rd_addr = addr_of(ptr_dec);
                        if (ptr_dec == '0) begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        state_next = ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        load_out     = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            ptr_reg     <= sat_count(RESET_COUNT, MAX_VALUES);
            byp_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            ptr_reg     <= ptr_next;
            byp_reg     <= byp_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg <= top_next;
        len_reg <= len_next;
        rej_reg <= rej_next;
        if (load_out) begin
            m_run_top_reg      <= top_reg;
            m_run_length_reg   <= len_reg;
            m_all_released_reg <= (ptr_reg == '0);
            m_rejected_reg     <= rej_reg;
        end
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign m_valid         = m_valid_reg;
    assign m_run_top       = m_run_top_reg;
    assign m_run_length    = m_run_length_reg;
    assign m_all_released  = m_all_released_reg;
    assign m_rejected      = m_rejected_reg;

endmodule

/* design/descending_run_resequencer_top.sv */
// top level of the descending run resequencer
// Values 1..total_count arrive in any order, one per input beat; each beat gives one
// result beat with the highest value released (run_top) and how many consecutive values
// were released downward from it (run_length, 0 when nothing is released). In the back
// end an item first marks its value in the presence map, then takes one map read per
// released value (the single read port of the map ram sets this), then a check that
// finds the next value absent, and then the result register is loaded once any waiting
// result has been taken by m_ready. The absent check is skipped when the run empties the
// pointer, and a rejected item or one that arrives after full release goes straight to
// loading the result. A two entry queue lets new beats be taken while the back end
// scans or the result waits. After reset, and again after a write of total_count, the
// map ram is cleared one entry a cycle, and s_ready stays low meanwhile. cfg_ready is
// always high, but total_count is only to be written while no beat is in flight.
module descending_run_resequencer_top import drr_pkg::*; #(
    parameter int MAX_VALUES = MAX_VALUES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [VAL_W-1:0] s_item_value,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [VAL_W-1:0] cfg_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_run_top,
    output logic [VAL_W-1:0] m_run_length,
    output logic             m_all_released,
    output logic             m_rejected
);

    logic         q_push;
    item_t        q_in_item;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;
    item_t        q_head;
    back_status_t status;
    restart_t     restart;

    drr_front #(
        .MAX_VALUES(MAX_VALUES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item_value(s_item_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_item      (q_in_item),
        .q_full      (q_full),
        .status      (status),
        .restart     (restart)
    );

    drr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_item (q_head)
    );

    drr_back #(
        .MAX_VALUES(MAX_VALUES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart       (restart),
        .status        (status),
        .q_valid       (q_valid),
        .q_item        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_run_top     (m_run_top),
        .m_run_length  (m_run_length),
        .m_all_released(m_all_released),
        .m_rejected    (m_rejected)
    );

`ifndef NO_ASSERTIONS
    // no beat gets in while the map is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready)
        else $error("input beat possible during map clear");

    // a config write blocks input until the clear has started
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready)
        else $error("input open right after config write");

    // a rejected beat releases nothing
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_run_top == '0 && m_run_length == '0)
        else $error("rejected beat carries a run");

    // a run counts down from its top and never passes below 1
    a_run_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_length != '0 |-> m_run_top >= m_run_length)
        else $error("run longer than its top value");
`endif

endmodule

/* sim/descending_run_resequencer_top_tb.sv */
// testbench for the descending run resequencer: queued driver, clocked monitor, run predictor
`timescale 1ns / 100ps

module descending_run_resequencer_top_tb import drr_pkg::*; ();

    typedef struct packed {
        logic [VAL_W-1:0] run_top;
        logic [VAL_W-1:0] run_length;
        logic             all_released;
        logic             rejected;
    } run_result_t;

    localparam int RX_HOLD_CYCLES = 1500;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [VAL_W-1:0] s_item_value = '0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [VAL_W-1:0] cfg_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [VAL_W-1:0] m_run_top;
    logic [VAL_W-1:0] m_run_length;
    logic             m_all_released;
    logic             m_rejected;

    logic [VAL_W-1:0] arrival_q[$];
    run_result_t      release_q[$];

    // predictor state
    int unsigned              exp_count = MAX_VALUES_DEF;
    int unsigned              exp_ptr = MAX_VALUES_DEF;
    logic [MAX_VALUES_DEF:0]  exp_present = '0;

    int  err_count = 0;
    int  rand_sent = 0;
    bit  idle_on = 1'b1;
    bit  s_taken = 1'b0;
    int  s_gap = 0;
    int  rx_gap = 0;
    int  rx_hold_left = 0;
    int  rx_hold_req = 0;
    int  rx_hold_ack = 0;

    descending_run_resequencer_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item_value   (s_item_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_run_top      (m_run_top),
        .m_run_length   (m_run_length),
        .m_all_released (m_all_released),
        .m_rejected     (m_rejected)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_500_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // append one item to the pending input list
    task automatic queue_item(input logic [VAL_W-1:0] v);
        arrival_q = {arrival_q, v};
        rand_sent++;
    endtask

    // reject an out of range value, else mark it and release the descending run from the pointer
    function automatic run_result_t release_runs(input logic [VAL_W-1:0] v);
        run_result_t r;
        int unsigned val;
        r = '0;
        val = v;
        if (val < 1 || val > exp_count) begin
            r.rejected = 1'b1;
        end else begin
            if (val <= exp_ptr) exp_present[val] = 1'b1;
            if (exp_ptr > 0 && exp_present[exp_ptr]) r.run_top = VAL_W'(exp_ptr);
            while (exp_ptr > 0 && exp_present[exp_ptr]) begin
                exp_present[exp_ptr] = 1'b0;
                exp_ptr--;
                r.run_length = r.run_length + 1'b1;
            end
        end
        r.all_released = (exp_ptr == 0);
        return r;
    endfunction

    // check result beats first, then predict for the accepted input beat
    always @(posedge aclk) begin : monitor
        run_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (release_q.size() == 0) begin
                report_mismatch("result beat with nothing pending, run_top", m_run_top, 0);
            end else begin
                want = release_q.pop_front();
                if (m_run_top !== want.run_top)
                    report_mismatch("run_top", m_run_top, want.run_top);
                if (m_run_length !== want.run_length)
                    report_mismatch("run_length", m_run_length, want.run_length);
                if (m_all_released !== want.all_released)
                    report_mismatch("all_released", m_all_released, want.all_released);
                if (m_rejected !== want.rejected)
                    report_mismatch("rejected", m_rejected, want.rejected);
            end
        end
        if (aresetn && s_valid && s_ready) begin
            release_q = {release_q, release_runs(s_item_value)};
        end
        s_taken <= aresetn && s_valid && s_ready;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (s_gap != 0) begin
                s_valid <= 1'b0;
                s_gap <= s_gap - 1;
            end else if (arrival_q.size() != 0) begin
                s_valid <= 1'b1;
                s_item_value <= arrival_q.pop_front();
                if (idle_on && $urandom_range(0, 4) == 0) s_gap <= $urandom_range(1, 6);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_hold_left != 0) begin
            m_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req != rx_hold_ack) begin
            m_ready <= 1'b0;
            rx_hold_ack <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_gap != 0) begin
            m_ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) rx_gap <= $urandom_range(1, 6);
        end
    end

    // checked at the rising edge where the driver's outputs are settled
    task automatic wait_drained();
        while (arrival_q.size() != 0 || s_valid || release_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_count(input logic [VAL_W-1:0] v);
        wait_drained();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        exp_count = (v > MAX_VALUES_DEF) ? MAX_VALUES_DEF : v;
        exp_ptr = exp_count;
        exp_present = '0;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] noise_value(input int n);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return VAL_W'($urandom_range(0, 2047));
            2: return VAL_W'($urandom_range(n + 1, 2047));
            default: return VAL_W'($urandom_range(1, (n > 0) ? n : 1));
        endcase
    endfunction

    // shuffled run of values with some noise; sometimes cut short
    task automatic run_random_phase(input int cfg_v, input bit hold_rx, input bit pause_mid);
        int n, lo, j, tmp, cut;
        int perm[$];
        write_count(VAL_W'(cfg_v));
        if (hold_rx) rx_hold_req++;
        n = (cfg_v > MAX_VALUES_DEF) ? MAX_VALUES_DEF : cfg_v;
        if (n <= 64) lo = 1;
        else lo = n - int'($urandom_range(3, 40)) + 1;
        for (int k = lo; k <= n; k++) perm = {perm, k};
        for (int k = perm.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        if (perm.size() == 0) begin
            repeat ($urandom_range(2, 8)) queue_item(noise_value(n));
        end
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, perm.size()) : perm.size();
        for (int k = 0; k < cut; k++) begin
            if ($urandom_range(0, 7) == 0) queue_item(noise_value(n));
            queue_item(VAL_W'(perm[k]));
            if (pause_mid && k == cut / 2) wait_drained();
        end
    endtask

    initial begin : stimulus
        int phase;
        int sel;
        int cfg_v;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset count: out of range values, duplicate above the pointer, single releases
        queue_item(11'd0);
        queue_item(11'd2047);
        queue_item(11'd1025);
        queue_item(11'd1);
        queue_item(11'd1024);
        queue_item(11'd1024);
        queue_item(11'd1023);

        // zero count rejects everything
        write_count(11'd0);
        queue_item(11'd0);
        queue_item(11'd1);

        // count above capacity saturates
        write_count(11'd2047);
        queue_item(11'd1024);

        write_count(11'd1);
        queue_item(11'd1);
        queue_item(11'd1);
        queue_item(11'd2);

        // full run released at once, then an item after full release
        write_count(11'd5);
        queue_item(11'd2);
        queue_item(11'd4);
        queue_item(11'd3);
        queue_item(11'd1);
        queue_item(11'd5);
        queue_item(11'd3);

        phase = 0;
        while (rand_sent < 1250) begin
            if (rand_sent > 1050) idle_on = 1'b0;
            sel = $urandom_range(0, 9);
            if (phase == 2) cfg_v = 30;
            else if (sel == 0) cfg_v = $urandom_range(0, 2047);
            else if (sel == 1) cfg_v = $urandom_range(1000, 1024);
            else if (sel == 2) cfg_v = $urandom_range(0, 3);
            else cfg_v = $urandom_range(4, 48);
            run_random_phase(cfg_v, phase == 2, phase == 4);
            phase++;
        end

        wait_drained();
        repeat (16) @(posedge aclk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
